>>> design/lame_pkg.sv
`default_nettype none

package lame_pkg;

    localparam int HEADER_BITS = 32;
    localparam int LEN_W       = 32;
    localparam int HDR_CNT_W   = $clog2(HEADER_BITS + 1);
    localparam int HDR_POS_W   = $clog2(HEADER_BITS);
    localparam int TOTAL_W     = 32;
    localparam int MAX_W       = 20;
    localparam int BYTES_W     = 20;
    localparam int NEED_W      = LEN_W + 4;
    localparam int CFG_DATA_W  = 32;
    localparam int SAMPLE_W    = 16;
    localparam int BYTE_W      = 8;
    localparam int BITPOS_W    = 3;

    localparam logic [MAX_W-1:0] MAX_MESSAGE_BYTES_RESET = MAX_W'(1000000);

    typedef logic [0:0] cfg_index_t;

    localparam cfg_index_t CFG_TOTAL_SAMPLES     = 1'b0;
    localparam cfg_index_t CFG_MAX_MESSAGE_BYTES = 1'b1;

    typedef struct packed {
        logic                       first_of_file;
        logic signed [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic              last;
        logic              status;
        logic [BYTE_W-1:0] byte_value;
    } result_t;

endpackage

`default_nettype wire

>>> design/lame_in_reg.sv
`default_nettype none

module lame_in_reg (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  lame_pkg::in_item_t s_item,
    output logic               item_valid,
    output lame_pkg::in_item_t item,
    input  wire                item_take
);
    import lame_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign valid_next = s_ready ? s_valid : valid_reg;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

>>> design/lame_decode.sv
`default_nettype none

module lame_decode (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_we,
    input  lame_pkg::cfg_index_t              cfg_index,
    input  wire [lame_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire                               item_valid,
    input  lame_pkg::in_item_t                item,
    input  wire                               out_space,
    output logic                              item_take,
    output logic                              res_valid,
    output lame_pkg::result_t                 res
);
    import lame_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    logic [TOTAL_W-1:0]   total_samples_reg;
    logic [MAX_W-1:0]     max_bytes_reg;

    phase_t               phase_reg, phase_next, phase_cur;
    logic [HDR_CNT_W-1:0] hbs_reg, hbs_next, hbs_cur;
    logic [LEN_W-1:0]     len_reg, len_next, len_cur;
    logic [BITPOS_W-1:0]  bitpos_reg, bitpos_next, bitpos_cur;
    logic [BYTE_W-1:0]    shift_reg, shift_next, shift_cur;
    logic [BYTES_W-1:0]   bytes_reg, bytes_next, bytes_cur;

    logic                 bit_in;
    logic [LEN_W-1:0]     len_new;
    logic [HDR_CNT_W-1:0] hbs_new;
    logic [NEED_W-1:0]    need;
    logic                 reject;
    logic [BYTE_W-1:0]    shift_new;
    logic [BYTES_W-1:0]   bytes_new;
    logic                 is_last;
    logic                 emit;

    assign item_take = item_valid && out_space;
    assign bit_in    = item.sample[0];

    always_comb begin
        if (item.first_of_file) begin
            phase_cur  = PH_HEADER;
            hbs_cur    = '0;
            len_cur    = '0;
            bitpos_cur = '0;
            shift_cur  = '0;
            bytes_cur  = '0;
        end else begin
            phase_cur  = phase_reg;
            hbs_cur    = hbs_reg;
            len_cur    = len_reg;
            bitpos_cur = bitpos_reg;
            shift_cur  = shift_reg;
            bytes_cur  = bytes_reg;
        end

        len_new   = len_cur | (LEN_W'(bit_in) << hbs_cur[HDR_POS_W-1:0]);
        hbs_new   = hbs_cur + HDR_CNT_W'(1);
        need      = NEED_W'(HEADER_BITS) + {1'b0, len_new, 3'b000};
        reject    = (len_new == '0)
                 || (len_new > LEN_W'(max_bytes_reg))
                 || (need > NEED_W'(total_samples_reg));
        shift_new = shift_cur | (BYTE_W'(bit_in) << bitpos_cur);
        bytes_new = bytes_cur + BYTES_W'(1);
        is_last   = (LEN_W'(bytes_new) == len_cur);

        phase_next  = phase_cur;
        hbs_next    = hbs_cur;
        len_next    = len_cur;
        bitpos_next = bitpos_cur;
        shift_next  = shift_cur;
        bytes_next  = bytes_cur;
        emit        = 1'b0;
        res         = '0;

        case (phase_cur)
            PH_HEADER: begin
                len_next = len_new;
                hbs_next = hbs_new;
                if (hbs_new >= HDR_CNT_W'(HEADER_BITS)) begin
                    bitpos_next = '0;
                    shift_next  = '0;
                    bytes_next  = '0;
                    if (reject) begin
                        phase_next = PH_DONE;
                        emit       = 1'b1;
                        res.status = 1'b1;
                        res.last   = 1'b1;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (bitpos_cur != BITPOS_W'(7)) begin
                    bitpos_next = bitpos_cur + BITPOS_W'(1);
                    shift_next  = shift_new;
                end else begin
                    bitpos_next    = '0;
                    bytes_next     = bytes_new;
                    shift_next     = '0;
                    emit           = 1'b1;
                    res.byte_value = shift_new;
                    res.last       = is_last;
                    if (is_last) begin
                        phase_next = PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign res_valid = item_take && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_samples_reg <= '0;
            max_bytes_reg     <= MAX_MESSAGE_BYTES_RESET;
            phase_reg         <= PH_HEADER;
            hbs_reg           <= '0;
            len_reg           <= '0;
            bitpos_reg        <= '0;
            shift_reg         <= '0;
            bytes_reg         <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TOTAL_SAMPLES:     total_samples_reg <= cfg_wdata[TOTAL_W-1:0];
                    CFG_MAX_MESSAGE_BYTES: max_bytes_reg     <= cfg_wdata[MAX_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (item_take) begin
                phase_reg  <= phase_next;
                hbs_reg    <= hbs_next;
                len_reg    <= len_next;
                bitpos_reg <= bitpos_next;
                shift_reg  <= shift_next;
                bytes_reg  <= bytes_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/lame_out_reg.sv
`default_nettype none

module lame_out_reg (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     res_valid,
    input  lame_pkg::result_t       res,
    output logic                    out_space,
    output logic                    m_valid,
    input  wire                     m_ready,
    output lame_pkg::result_t       m_res
);
    import lame_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_space  = !valid_reg || m_ready;
    assign valid_next = out_space ? res_valid : valid_reg;
    assign m_valid    = valid_reg;
    assign m_res      = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (out_space && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

>>> design/lsb_audio_message_extractor.sv
// Recovers a message hidden in the LSBs of 16-bit audio samples.
// Input stream (s_*): one sample per request, s_tuser = first_of_file restarts
// decoding with that sample as header bit 0. The first 32 LSBs give the
// message length in bytes, LSB first; every following 8 LSBs give one byte.
// Output stream (m_*): one request per finished byte (m_tuser = 0), m_tlast
// on the final byte; or a single rejection request (data 0, m_tuser = 1,
// m_tlast = 1) when the length is zero, above max_message_bytes, or when
// 32 + 8*length exceeds total_samples. Samples after that give nothing.
// Config: cfg_we/cfg_index/cfg_wdata, index 0 total_samples, 1
// max_message_bytes; write only while the stream is idle.
// A taken sample is held in the input register; its result, if any, is
// written to the result register. Throughput: one sample per cycle unless
// m_tready stalls, set by the single decode stage between the two registers.
// Reset (aresetn low, synchronous): both stages empty, header phase,
// total_samples 0, max_message_bytes 1000000.
// A stalled m_tready holds the result; s_tready drops once the input register
// holds a sample, so at most one more sample is absorbed.
`default_nettype none

module lsb_audio_message_extractor (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_we,
    input  lame_pkg::cfg_index_t           cfg_index,
    input  wire [lame_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [15:0]                     s_tdata,   // [15:0] sample
    input  wire                            s_tuser,   // [0] first_of_file
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] byte_value
    output logic                           m_tuser,   // [0] status
    output logic                           m_tlast
);
    import lame_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     item_take;
    logic     out_space;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    assign s_item.sample        = s_tdata;
    assign s_item.first_of_file = s_tuser;

    lame_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    lame_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .out_space  (out_space),
        .item_take  (item_take),
        .res_valid  (res_valid),
        .res        (res)
    );

    lame_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_space (out_space),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = m_res.byte_value;
    assign m_tuser = m_res.status;
    assign m_tlast = m_res.last;

endmodule

`default_nettype wire
